// File: hw/rtl/soa_pkg.sv
// shared types and constants for the slot occupancy allocator
`timescale 1ns / 1ps

package soa_pkg;

    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_LOCATE  = 2'd2,
        MODE_COMPACT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        t_mode mode;
        t_cnt  rank;
    } t_req;

    typedef struct packed {
        t_slot   slot;
        t_slot   source_slot;
        logic    is_move;
        t_status status;
        t_cnt    used_count;
        logic    last;
    } t_rsp;

    // update request from the sequencer to the occupancy bitmap
    typedef struct packed {
        logic  set;
        logic  clr;
        logic  pack;
        t_slot idx;
        t_cnt  used;
    } t_bmp_cmd;

endpackage

// File: hw/rtl/slot_occupancy_allocator_unit.sv
// top level: bitmap slot allocator with rank select and compaction
`timescale 1ns / 1ps

// usage
//   request channel (i_in_valid / o_in_ready / i_in_data): mode and rank
//   response channel (o_out_valid / i_out_ready / o_out_data): one response per
//     request, or one per relocated entry for compact, last set on the final one
//   every response carries the used count after the request
// timing
//   a request is taken only in idle; a scan counter then walks the bitmap one
//   slot a cycle, unless back-pressure holds it, through a single probe and a
//   single count compare; allocate scans up to the first free slot, free and
//   locate up to the target slot, and an out-of-range rank is answered unscanned
//   compact: scans up to the highest used slot, all slots when nothing has to
//   move; the bitmap is rewritten packed together with the last response
//   responses leave through an output register, so the next request is taken
//   while the previous response still waits
// reset
//   synchronous, active low; all slots free, used count zero, no response held
// back-pressure
//   while the output register is full and not taken, the scan holds on the
//   slot it wants to report

module slot_occupancy_allocator_unit #(
    parameter int SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  soa_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output soa_pkg::t_rsp o_out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state            r_state, n_state;
    soa_pkg::t_req     r_req, n_req;
    logic [IW-1:0]     r_idx, n_idx;
    logic [UW-1:0]     r_cnt, n_cnt;
    logic [UW-1:0]     r_used, n_used;
    logic              r_ovalid, n_ovalid;
    soa_pkg::t_rsp     r_odata, n_odata;

    soa_pkg::t_bmp_cmd bmp_cmd;
    logic              bmp_bit;
    logic              bmp_above;

    logic              can_emit;
    logic              last_idx;
    logic              rank_bad;
    logic              rank_hit;
    logic              is_gap;

    function automatic soa_pkg::t_rsp mk_rsp(
        input soa_pkg::t_slot   slot,
        input soa_pkg::t_slot   src,
        input logic             mv,
        input soa_pkg::t_status st,
        input soa_pkg::t_cnt    used,
        input logic             last
    );
        soa_pkg::t_rsp r;
        r.slot        = slot;
        r.source_slot = src;
        r.is_move     = mv;
        r.status      = st;
        r.used_count  = used;
        r.last        = last;
        return r;
    endfunction

    soa_bitmap #(
        .SLOTS (SLOTS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bmp_cmd),
        .o_bit   (bmp_bit),
        .o_above (bmp_above)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // output register free this cycle
    assign can_emit = !r_ovalid || i_out_ready;
    assign last_idx = (r_idx == IW'(SLOTS - 1));
    // rank zero or beyond the used count finds nothing
    assign rank_bad = (r_req.rank == '0) || (r_req.rank > soa_pkg::t_cnt'(r_used));
    assign rank_hit = (soa_pkg::t_cnt'(r_cnt) + soa_pkg::t_cnt'(1)) == r_req.rank;
    // used slot that sits above its packed position
    assign is_gap   = bmp_bit && (soa_pkg::t_cnt'(r_idx) != soa_pkg::t_cnt'(r_cnt));

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_used   = r_used;
        n_ovalid = r_ovalid && !i_out_ready;
        n_odata  = r_odata;

        bmp_cmd      = '0;
        bmp_cmd.idx  = soa_pkg::t_slot'(r_idx);
        bmp_cmd.used = soa_pkg::t_cnt'(r_used);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                unique case (r_req.mode)
                    soa_pkg::MODE_ALLOC: begin
                        if (!bmp_bit) begin
                            if (can_emit) begin
                                bmp_cmd.set = 1'b1;
                                n_used      = r_used + UW'(1);
                                n_ovalid    = 1'b1;
                                n_odata     = mk_rsp(soa_pkg::t_slot'(r_idx), '0, 1'b0,
                                                     soa_pkg::ST_OK,
                                                     soa_pkg::t_cnt'(n_used), 1'b1);
                                n_state     = S_IDLE;
                            end
                        end else if (last_idx) begin
                            if (can_emit) begin
                                n_ovalid = 1'b1;
                                n_odata  = mk_rsp('0, '0, 1'b0, soa_pkg::ST_FULL,
                                                  soa_pkg::t_cnt'(r_used), 1'b1);
                                n_state  = S_IDLE;
                            end
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                    soa_pkg::MODE_FREE, soa_pkg::MODE_LOCATE: begin
                        if (rank_bad) begin
                            if (can_emit) begin
                                n_ovalid = 1'b1;
                                n_odata  = mk_rsp('0, '0, 1'b0, soa_pkg::ST_NONE,
                                                  soa_pkg::t_cnt'(r_used), 1'b1);
                                n_state  = S_IDLE;
                            end
                        end else if (bmp_bit && rank_hit) begin
                            if (can_emit) begin
                                if (r_req.mode == soa_pkg::MODE_FREE) begin
                                    bmp_cmd.clr = 1'b1;
                                    n_used      = r_used - UW'(1);
                                end
                                n_ovalid = 1'b1;
                                n_odata  = mk_rsp(soa_pkg::t_slot'(r_idx), '0, 1'b0,
                                                  soa_pkg::ST_OK,
                                                  soa_pkg::t_cnt'(n_used), 1'b1);
                                n_state  = S_IDLE;
                            end
                        end else begin
                            if (bmp_bit) begin
                                n_cnt = r_cnt + UW'(1);
                            end
                            n_idx = r_idx + IW'(1);
                        end
                    end
                    soa_pkg::MODE_COMPACT: begin
                        if (is_gap) begin
                            // move is last when nothing used lies above it
                            if (can_emit) begin
                                n_ovalid = 1'b1;
                                n_odata  = mk_rsp(soa_pkg::t_slot'(r_cnt),
                                                  soa_pkg::t_slot'(r_idx), 1'b1,
                                                  soa_pkg::ST_OK,
                                                  soa_pkg::t_cnt'(r_used), !bmp_above);
                                if (!bmp_above) begin
                                    bmp_cmd.pack = 1'b1;
                                    n_state      = S_IDLE;
                                end else begin
                                    n_cnt = r_cnt + UW'(1);
                                    n_idx = r_idx + IW'(1);
                                end
                            end
                        end else if (last_idx) begin
                            // end reached without any move: already packed
                            if (can_emit) begin
                                bmp_cmd.pack = 1'b1;
                                n_ovalid     = 1'b1;
                                n_odata      = mk_rsp('0, '0, 1'b0, soa_pkg::ST_OK,
                                                      soa_pkg::t_cnt'(r_used), 1'b1);
                                n_state      = S_IDLE;
                            end
                        end else begin
                            if (bmp_bit) begin
                                n_cnt = r_cnt + UW'(1);
                            end
                            n_idx = r_idx + IW'(1);
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_odata <= n_odata;
    end

endmodule

// File: hw/rtl/soa_bitmap.sv
// occupancy bitmap with single-bit probe and packed rewrite
`timescale 1ns / 1ps

module soa_bitmap #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  soa_pkg::t_bmp_cmd i_cmd,
    output logic              o_bit,
    output logic              o_above
);

    localparam int IW = $clog2(SLOTS);

    logic [SLOTS-1:0] r_occ;
    logic [SLOTS-1:0] n_occ;
    logic [SLOTS-1:0] hi_mask;
    logic [IW-1:0]    idx_l;

    assign idx_l = i_cmd.idx[IW-1:0];
    assign o_bit = r_occ[idx_l];

    // any used slot strictly above the probed index
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            hi_mask[j] = (IW'(j) > idx_l);
        end
    end
    assign o_above = |(r_occ & hi_mask);

    always_comb begin
        n_occ = r_occ;
        priority if (i_cmd.pack) begin
            for (int j = 0; j < SLOTS; j++) begin
                n_occ[j] = (soa_pkg::t_cnt'(j) < i_cmd.used);
            end
        end else if (i_cmd.set) begin
            n_occ[idx_l] = 1'b1;
        end else if (i_cmd.clr) begin
            n_occ[idx_l] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

endmodule

// File: hw/rtl/soa_checker.sv
// port-level checks for the slot occupancy allocator, bound to the top level
`timescale 1ns / 1ps

module soa_checker #(
    parameter int SLOTS = 64
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input soa_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input soa_pkg::t_rsp o_out_data
);

    // a taken request leaves the block busy in the following cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken back to back");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response dropped or changed under stall");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.used_count <= soa_pkg::t_cnt'(SLOTS))
        else $error("used count beyond store size");

    // full only when every slot is used
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == soa_pkg::ST_FULL
            |-> o_out_data.used_count == soa_pkg::t_cnt'(SLOTS))
        else $error("full reported with free slots");

    a_src_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_move |-> o_out_data.source_slot == '0)
        else $error("source slot set outside a move");

endmodule

bind slot_occupancy_allocator_unit soa_checker #(
    .SLOTS (SLOTS)
) u_soa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: bench/slot_occupancy_allocator_unit_tb.sv
// self-checking testbench for the slot occupancy allocator top level
`timescale 1ns / 1ps

module slot_occupancy_allocator_unit_tb;

    localparam int          SLOTS      = 64;
    localparam int          RAND_ITEMS = 100;
    localparam int unsigned RUN_LIMIT  = 1_000_000;
    // a full scan plus the output register, with margin
    localparam int          DRAIN_CYC  = 2 * SLOTS + 8;
    localparam int          DIR_N      = 19;

    // kinds of random stretch the sender works through
    typedef enum int {
        EP_ALLOC,
        EP_FREE,
        EP_LOCATE,
        EP_COMPACT,
        EP_FILL,
        EP_NOISE
    } t_episode;

    // one directed request, with its response typed in where it is obvious
    typedef struct packed {
        soa_pkg::t_req req;
        logic          typed;
        soa_pkg::t_rsp rsp;
    } t_dir_row;

    localparam soa_pkg::t_rsp NO_RSP = '0;

    // the store starts empty after reset; the rows walk it through the odd
    // rank cases, compaction of an empty store, a single move and a no-op pack
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // empty store: nothing to locate or free, nothing to pack
        '{'{soa_pkg::MODE_LOCATE, 7'd1}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_NONE, 7'd0, 1'b1}},
        '{'{soa_pkg::MODE_FREE, 7'd0}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_NONE, 7'd0, 1'b1}},
        '{'{soa_pkg::MODE_FREE, 7'd127}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_NONE, 7'd0, 1'b1}},
        '{'{soa_pkg::MODE_COMPACT, 7'd0}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_OK, 7'd0, 1'b1}},
        // first allocations fill from the bottom
        '{'{soa_pkg::MODE_ALLOC, 7'd0}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_OK, 7'd1, 1'b1}},
        '{'{soa_pkg::MODE_ALLOC, 7'd0}, 1'b1,
          '{6'd1, 6'd0, 1'b0, soa_pkg::ST_OK, 7'd2, 1'b1}},
        '{'{soa_pkg::MODE_ALLOC, 7'd0}, 1'b1,
          '{6'd2, 6'd0, 1'b0, soa_pkg::ST_OK, 7'd3, 1'b1}},
        '{'{soa_pkg::MODE_ALLOC, 7'd0}, 1'b1,
          '{6'd3, 6'd0, 1'b0, soa_pkg::ST_OK, 7'd4, 1'b1}},
        // rank zero and rank one past the used count
        '{'{soa_pkg::MODE_LOCATE, 7'd0}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_NONE, 7'd4, 1'b1}},
        '{'{soa_pkg::MODE_LOCATE, 7'd5}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_NONE, 7'd4, 1'b1}},
        // the rest follow the predictor, but for one typed out-of-range locate
        '{'{soa_pkg::MODE_LOCATE,  7'd4},   1'b0, NO_RSP},
        '{'{soa_pkg::MODE_FREE,    7'd1},   1'b0, NO_RSP},
        '{'{soa_pkg::MODE_FREE,    7'd2},   1'b0, NO_RSP},
        '{'{soa_pkg::MODE_ALLOC,   7'd0},   1'b0, NO_RSP},
        '{'{soa_pkg::MODE_COMPACT, 7'd0},   1'b0, NO_RSP},
        '{'{soa_pkg::MODE_COMPACT, 7'd127}, 1'b0, NO_RSP},
        '{'{soa_pkg::MODE_LOCATE, 7'd64}, 1'b1,
          '{6'd0, 6'd0, 1'b0, soa_pkg::ST_NONE, 7'd3, 1'b1}},
        '{'{soa_pkg::MODE_FREE,    7'd3},   1'b0, NO_RSP},
        '{'{soa_pkg::MODE_ALLOC,   7'd127}, 1'b0, NO_RSP}
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    soa_pkg::t_req i_in_data;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    soa_pkg::t_rsp o_out_data;

    // predicted occupancy and the responses still owed by the block
    logic [SLOTS-1:0] occ_map = '0;
    soa_pkg::t_rsp    pending_rsp[$];

    int          mismatch_cnt = 0;
    int unsigned run_cycles   = 0;
    int          burst_left   = 0;

    // receiver stall pattern state
    int stall_style = 0;
    int style_left  = 0;
    int run_left    = 0;

    slot_occupancy_allocator_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // work out the responses a request causes and move the bitmap on
    task automatic predict_occupancy(input soa_pkg::t_req req);
        int            used;
        int            hit;
        int            seen;
        int            dst;
        soa_pkg::t_rsp r;
        soa_pkg::t_rsp held;
        logic          have_held;
        used      = $countones(occ_map);
        hit       = -1;
        seen      = 0;
        dst       = 0;
        have_held = 1'b0;
        r         = '0;
        held      = '0;
        r.last    = 1'b1;
        case (req.mode)
            soa_pkg::MODE_ALLOC: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!occ_map[i] && hit < 0) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = soa_pkg::ST_FULL;
                end else begin
                    occ_map[hit] = 1'b1;
                    r.slot       = soa_pkg::t_slot'(hit);
                end
                r.used_count = soa_pkg::t_cnt'($countones(occ_map));
                pending_rsp.push_back(r);
            end
            soa_pkg::MODE_FREE, soa_pkg::MODE_LOCATE: begin
                // one-based rank among used slots, ascending index
                if (req.rank != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (occ_map[i]) begin
                            seen++;
                            if (seen == int'(req.rank) && hit < 0) begin
                                hit = i;
                            end
                        end
                    end
                end
                if (hit < 0) begin
                    r.status = soa_pkg::ST_NONE;
                end else begin
                    if (req.mode == soa_pkg::MODE_FREE) begin
                        occ_map[hit] = 1'b0;
                    end
                    r.slot = soa_pkg::t_slot'(hit);
                end
                r.used_count = soa_pkg::t_cnt'($countones(occ_map));
                pending_rsp.push_back(r);
            end
            default: begin
                // compact: one move per entry that changes place, the final
                // one held back so that it can carry last
                for (int i = 0; i < SLOTS; i++) begin
                    if (occ_map[i]) begin
                        if (i != dst) begin
                            if (have_held) begin
                                pending_rsp.push_back(held);
                            end
                            held             = '0;
                            held.slot        = soa_pkg::t_slot'(dst);
                            held.source_slot = soa_pkg::t_slot'(i);
                            held.is_move     = 1'b1;
                            held.used_count  = soa_pkg::t_cnt'(used);
                            have_held        = 1'b1;
                        end
                        dst++;
                    end
                end
                for (int i = 0; i < SLOTS; i++) begin
                    occ_map[i] = (i < used);
                end
                if (have_held) begin
                    held.last = 1'b1;
                    pending_rsp.push_back(held);
                end else begin
                    r.used_count = soa_pkg::t_cnt'(used);
                    pending_rsp.push_back(r);
                end
            end
        endcase
    endtask

    // present one request, wait for it to be taken, then idle per burst
    task automatic send_request(input soa_pkg::t_req req, input logic typed,
                                input soa_pkg::t_rsp typed_rsp);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_occupancy(req);
        // a typed-in response replaces the predicted one for this request
        if (typed) begin
            void'(pending_rsp.pop_back());
            pending_rsp.push_back(typed_rsp);
        end
        // valid stays up inside a burst, drops for a random gap between bursts
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic note_mismatch(input string what, input soa_pkg::t_rsp want,
                                 input soa_pkg::t_rsp got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("mismatch (%s): expected slot %0d src %0d move %0d status %0d used %0d last %0d",
                     what, want.slot, want.source_slot, want.is_move, want.status,
                     want.used_count, want.last);
            $display("                got      slot %0d src %0d move %0d status %0d used %0d last %0d",
                     got.slot, got.source_slot, got.is_move, got.status,
                     got.used_count, got.last);
        end
    endtask

    // response checker: oldest expectation first, field by field
    always @(posedge i_clk) begin : rsp_check
        soa_pkg::t_rsp want;
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                note_mismatch("unexpected", '0, o_out_data);
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.slot !== want.slot
                        || o_out_data.source_slot !== want.source_slot
                        || o_out_data.is_move !== want.is_move
                        || o_out_data.status !== want.status
                        || o_out_data.used_count !== want.used_count
                        || o_out_data.last !== want.last) begin
                    note_mismatch("field", want, o_out_data);
                end
            end
        end
    end

    // receiver: switches between always ready, coin-toss ready and long stalls
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            style_left  <= $urandom_range(40, 160);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    i_out_ready <= ~i_out_ready;
                    run_left    <= i_out_ready ? $urandom_range(1, 12) : $urandom_range(1, 4);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles >= RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        soa_pkg::t_req req;
        t_episode      ep_kind;
        int            ep_left;
        int            n_rand;
        int            used;
        int            pick;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < DIR_N; k++) begin
            send_request(DIR_ROWS[k].req, DIR_ROWS[k].typed, DIR_ROWS[k].rsp);
        end

        // random part: opens by filling the store past full, then mixes
        // allocate runs, refills, frees and locates, packs and noise
        n_rand  = 0;
        ep_kind = EP_FILL;
        ep_left = SLOTS + 3;
        while (n_rand < RAND_ITEMS) begin
            used = $countones(occ_map);
            if (ep_left == 0) begin
                pick = $urandom_range(0, 11);
                if (pick <= 3) begin
                    ep_kind = EP_ALLOC;
                    ep_left = $urandom_range(1, 16);
                end else if (pick <= 6) begin
                    ep_kind = EP_FREE;
                    ep_left = $urandom_range(1, 8);
                end else if (pick <= 8) begin
                    ep_kind = EP_LOCATE;
                    ep_left = $urandom_range(1, 6);
                end else if (pick == 9) begin
                    ep_kind = EP_COMPACT;
                    ep_left = 1;
                end else if (pick == 10) begin
                    ep_kind = EP_FILL;
                    ep_left = SLOTS - used + $urandom_range(1, 3);
                end else begin
                    ep_kind = EP_NOISE;
                    ep_left = $urandom_range(1, 4);
                end
            end
            req.rank = soa_pkg::t_cnt'($urandom_range(0, 127));
            case (ep_kind)
                EP_ALLOC, EP_FILL: req.mode = soa_pkg::MODE_ALLOC;
                EP_COMPACT:        req.mode = soa_pkg::MODE_COMPACT;
                EP_FREE, EP_LOCATE: begin
                    req.mode = (ep_kind == EP_FREE) ? soa_pkg::MODE_FREE
                                                    : soa_pkg::MODE_LOCATE;
                    // mostly a rank that exists, now and then a broken one
                    if (used > 0 && $urandom_range(0, 7) != 0) begin
                        req.rank = soa_pkg::t_cnt'($urandom_range(1, used));
                    end else if ($urandom_range(0, 1) == 0) begin
                        req.rank = '0;
                    end else begin
                        req.rank = soa_pkg::t_cnt'($urandom_range(used + 1, 127));
                    end
                end
                default: req.mode = soa_pkg::t_mode'($urandom_range(0, 3));
            endcase
            send_request(req, 1'b0, NO_RSP);
            ep_left--;
            n_rand++;
        end
        i_in_valid <= 1'b0;

        // let every owed response arrive, then watch for strays
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
